>>> sv/idtv_pkg.sv
// ----------------------------------------------------------------------------
// idtv_pkg - shared types and constants of the date text validator
// character codes, field limits and the per-text parse state
// ----------------------------------------------------------------------------
package idtv_pkg;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // field limits
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] MONTH_MAX  = 14'd12;
    localparam logic [13:0] DAY_MAX    = 14'd31;
    localparam logic [13:0] ACC_SAT    = 14'd10000;
    localparam logic [13:0] ACC_SAT_AT = 14'd1000;

    // which field of the text is being read
    typedef enum logic [2:0] {
        FLD_YEAR  = 3'b001,
        FLD_MONTH = 3'b010,
        FLD_DAY   = 3'b100
    } field_t;

    // number text phase inside one field
    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_ENDED  = 4'b1000
    } phase_t;

    typedef struct packed {
        field_t          fld;
        phase_t          phase;
        logic            neg;
        logic [13:0]     acc;
        logic [3:0][3:0] digits;       // last four digits of the field, [0] newest
        logic [13:0]     stored_year;
        logic [3:0]      stored_month;
        logic            leap;         // stored year is a leap year
        logic            error_seen;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        fld:          FLD_YEAR,
        phase:        PH_SKIP,
        neg:          1'b0,
        acc:          14'd0,
        digits:       16'd0,
        stored_year:  14'd0,
        stored_month: 4'd0,
        leap:         1'b0,
        error_seen:   1'b0
    };

endpackage

>>> sv/idtv_field_parse.sv
// ----------------------------------------------------------------------------
// idtv_field_parse - one character step of the date text parser
// next parse state from the current state and one text byte
// ----------------------------------------------------------------------------
module idtv_field_parse (
    input  idtv_pkg::parse_state_t cur,
    input  logic [7:0]             text_byte,
    output idtv_pkg::parse_state_t nxt
);
    import idtv_pkg::*;

    logic        is_digit;
    logic        is_space;
    logic [3:0]  dig;
    logic [7:0]  dig_full;
    logic [13:0] acc_dec;
    logic        has_digits;
    logic        year_ok;
    logic        month_ok;
    logic        y4;
    logic        y100;
    logic        y400;
    logic [1:0]  low_mod4;
    logic [1:0]  high_mod4;

    assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign is_space = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
    assign dig_full = text_byte - CH_ZERO;
    assign dig      = dig_full[3:0];

    // acc * 10 + digit, only used while acc is below the saturation point
    assign acc_dec = (cur.acc << 3) + (cur.acc << 1) + {10'd0, dig};

    assign has_digits = ((cur.phase == PH_DIGITS) || (cur.phase == PH_ENDED)) && !cur.neg;
    assign year_ok    = has_digits && (cur.acc >= 14'd1) && (cur.acc <= YEAR_MAX);
    assign month_ok   = has_digits && (cur.acc >= 14'd1) && (cur.acc <= MONTH_MAX);

    // leap rule from decimal digits: 100 is a multiple of 4, so only two digits matter
    assign low_mod4  = {cur.digits[1][0], 1'b0} + cur.digits[0][1:0];
    assign high_mod4 = {cur.digits[3][0], 1'b0} + cur.digits[2][1:0];
    assign y4        = (low_mod4 == 2'd0);
    assign y100      = (cur.digits[1] == 4'd0) && (cur.digits[0] == 4'd0);
    assign y400      = y100 && (high_mod4 == 2'd0);

    always_comb
    begin
        nxt = cur;
        if ((text_byte == CH_MINUS) && (cur.fld != FLD_DAY))
        begin
            // field separator
            if (cur.fld == FLD_YEAR)
            begin
                if (!year_ok)
                    nxt.error_seen = 1'b1;
                nxt.stored_year = cur.acc;
                nxt.leap        = (y4 && !y100) || y400;
                nxt.fld         = FLD_MONTH;
            end
            else
            begin
                if (!month_ok)
                    nxt.error_seen = 1'b1;
                nxt.stored_month = cur.acc[3:0];
                nxt.fld          = FLD_DAY;
            end
            nxt.phase  = PH_SKIP;
            nxt.neg    = 1'b0;
            nxt.acc    = 14'd0;
            nxt.digits = '0;
        end
        else if (cur.phase == PH_ENDED)
        begin
            // rest of the field after a nul is ignored
        end
        else if (text_byte == CH_NUL)
        begin
            if (cur.phase == PH_DIGITS)
                nxt.phase = PH_ENDED;
            else
                nxt.error_seen = 1'b1;
        end
        else if (is_digit)
        begin
            nxt.acc    = (cur.acc >= ACC_SAT_AT) ? ACC_SAT : acc_dec;
            nxt.phase  = PH_DIGITS;
            nxt.digits = {cur.digits[2:0], dig};
        end
        else if ((cur.phase == PH_SKIP) && is_space)
        begin
            // leading whitespace
        end
        else if ((cur.phase == PH_SKIP) && ((text_byte == CH_PLUS) || (text_byte == CH_MINUS)))
        begin
            nxt.neg   = (text_byte == CH_MINUS);
            nxt.phase = PH_SIGN;
        end
        else
        begin
            nxt.error_seen = 1'b1;
        end
    end

endmodule

>>> sv/iso_date_text_validator_top.sv
// ----------------------------------------------------------------------------
// iso_date_text_validator_top - YEAR-MONTH-DAY text checker
// parses a date text one byte per word and reports the calendar date
// ----------------------------------------------------------------------------
// result path: the final byte of a text passes the input register, then the
//   result register, from which its result word leaves
// throughput: one byte per cycle, but the last byte of a text waits while the result register is full and stalled
// reset: rst_n clears the parse state, both valid flags and any half-read text
// ----------------------------------------------------------------------------
module iso_date_text_validator_top (
    input  logic        clk,
    input  logic        rst_n,
    // byte channel
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic        valid_res,
    output logic [13:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day
);
    import idtv_pkg::*;

    // month codes with a short length
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;

    // input register
    logic        bvalid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    // parse state, one text at a time
    parse_state_t state_reg;
    parse_state_t state_next;

    // result register
    logic        res_valid_reg;
    logic        ok_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    logic        res_free;
    logic        proc;
    logic        day_ok;
    logic        date_ok;
    logic [4:0]  mdays;

    // days in a month, february from the leap flag taken when the year closed
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB:                            len = leap ? 5'd29 : 5'd28;
            default:                            len = 5'd31;
        endcase
        return len;
    endfunction

    // per-byte parse step
    idtv_field_parse u_parse (
        .cur       (state_reg),
        .text_byte (byte_reg),
        .nxt       (state_next)
    );

    // result register can take a word when empty or being drained
    assign res_free = !res_valid_reg || !res_stall;
    // a byte that ends no text never waits on the result side
    assign proc       = bvalid_reg && (!last_reg || res_free);
    assign byte_stall = bvalid_reg && !proc;

    // final check on the state after the last byte
    assign mdays  = month_len(state_next.stored_month, state_next.leap);
    assign day_ok = ((state_next.phase == PH_DIGITS) || (state_next.phase == PH_ENDED))
                    && !state_next.neg
                    && (state_next.acc >= 14'd1)
                    && (state_next.acc <= DAY_MAX)
                    && (state_next.acc[4:0] <= mdays);
    assign date_ok = !state_next.error_seen && (state_next.fld == FLD_DAY) && day_ok;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bvalid_reg <= 1'b0;
        else if (!byte_stall)
            bvalid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            byte_reg <= text_byte;
            last_reg <= last_byte;
        end
    end

    // parse state, cleared after the last byte of every text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PARSE_RESET;
        else if (proc)
            state_reg <= last_reg ? PARSE_RESET : state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_free)
            res_valid_reg <= proc && last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (proc && last_reg)
        begin
            // an invalid text reports zero fields
            ok_reg    <= date_ok;
            year_reg  <= date_ok ? state_next.stored_year : 14'd0;
            month_reg <= date_ok ? state_next.stored_month : 4'd0;
            day_reg   <= date_ok ? state_next.acc[4:0] : 5'd0;
        end
    end

    assign res_valid = res_valid_reg;
    assign valid_res = ok_reg;
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;

endmodule

>>> tb/iso_date_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_date_checker - result checker for the date text validator
// follows every accepted byte with its own parser, queues the expected date
// word at the end of each text and compares it with each accepted result word
// ----------------------------------------------------------------------------
module iso_date_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic        valid_res,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    output int          mismatch_count,
    output int          dates_pending
);
    import idtv_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [13:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
    } date_word_t;

    date_word_t  expected_dates[$];

    // parser state of the text being read
    field_t      cur_field;
    phase_t      cur_phase;
    logic        minus_seen;
    logic [13:0] digit_acc;
    logic [13:0] held_year;
    logic [3:0]  held_month;
    logic        bad_text;
    int          shown;

    function automatic void clear_text();
        cur_field  = FLD_YEAR;
        cur_phase  = PH_SKIP;
        minus_seen = 1'b0;
        digit_acc  = '0;
        held_year  = '0;
        held_month = '0;
        bad_text   = 1'b0;
    endfunction

    // digits seen, no minus sign, value in range
    function automatic logic number_fits(input logic [13:0] lo, input logic [13:0] hi);
        return (cur_phase == PH_DIGITS || cur_phase == PH_ENDED) && !minus_seen &&
               digit_acc >= lo && digit_acc <= hi;
    endfunction

    function automatic void absorb_char(input logic [7:0] ch);
        if (ch == CH_MINUS && cur_field != FLD_DAY) begin
            if (cur_field == FLD_YEAR) begin
                if (!number_fits(14'd1, YEAR_MAX))
                    bad_text = 1'b1;
                held_year = digit_acc;
                cur_field = FLD_MONTH;
            end
            else begin
                if (!number_fits(14'd1, MONTH_MAX))
                    bad_text = 1'b1;
                held_month = digit_acc[3:0];
                cur_field  = FLD_DAY;
            end
            cur_phase  = PH_SKIP;
            minus_seen = 1'b0;
            digit_acc  = '0;
        end
        else if (cur_phase == PH_ENDED) begin
            // rest of the field after a nul is dropped
        end
        else if (ch == CH_NUL) begin
            if (cur_phase == PH_DIGITS)
                cur_phase = PH_ENDED;
            else
                bad_text = 1'b1;
        end
        else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (digit_acc >= ACC_SAT_AT)
                digit_acc = ACC_SAT;
            else
                digit_acc = 14'(digit_acc * 10 + (ch - CH_ZERO));
            cur_phase = PH_DIGITS;
        end
        else if (cur_phase == PH_SKIP &&
                 (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))) begin
            // leading whitespace
        end
        else if (cur_phase == PH_SKIP && (ch == CH_PLUS || ch == CH_MINUS)) begin
            minus_seen = (ch == CH_MINUS);
            cur_phase  = PH_SIGN;
        end
        else begin
            bad_text = 1'b1;
        end
    endfunction

    // verdict for the finished text, parser cleared for the next one
    function automatic date_word_t close_text();
        logic       ok;
        logic       leap;
        logic [4:0] mlen;
        date_word_t w;
        ok   = !bad_text && cur_field == FLD_DAY && number_fits(14'd1, DAY_MAX);
        leap = (held_year % 4 == 0 && held_year % 100 != 0) || held_year % 400 == 0;
        case (held_month)
            4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
            4'd2:                    mlen = leap ? 5'd29 : 5'd28;
            default:                 mlen = 5'd31;
        endcase
        if (ok && digit_acc > mlen)
            ok = 1'b0;
        if (ok)
            w = '{1'b1, held_year, held_month, digit_acc[4:0]};
        else
            w = '0;
        clear_text();
        return w;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        date_word_t want;
        date_word_t got;
        if (!rst_n) begin
            clear_text();
            expected_dates.delete();
            shown          = 0;
            mismatch_count <= 0;
            dates_pending  <= 0;
        end
        else begin
            if (byte_valid && !byte_stall) begin
                absorb_char(text_byte);
                if (last_byte)
                    expected_dates.push_back(close_text());
            end
            if (res_valid && !res_stall) begin
                got = '{valid_res, year, month, day};
                if (expected_dates.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (shown < 10)
                        $display("%0t: result word with none expected: valid=%0d %0d-%0d-%0d",
                                 $realtime, got.ok, got.yr, got.mo, got.dy);
                    shown++;
                end
                else begin
                    want = expected_dates.pop_front();
                    if (want.ok !== got.ok || want.yr !== got.yr ||
                        want.mo !== got.mo || want.dy !== got.dy) begin
                        mismatch_count <= mismatch_count + 1;
                        if (shown < 10)
                            $display({"%0t: date mismatch: expected valid=%0d %0d-%0d-%0d,",
                                      " got valid=%0d %0d-%0d-%0d"},
                                     $realtime, want.ok, want.yr, want.mo, want.dy,
                                     got.ok, got.yr, got.mo, got.dy);
                        shown++;
                    end
                end
            end
            dates_pending <= expected_dates.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the date text validator
// feeds date texts one byte per word (directed corner cases, then random
// well-formed, mangled and noise texts) with random gaps and result stalls;
// the checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_top;
    import idtv_pkg::*;

    localparam int BYTE_GOAL    = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PCT     = 20;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  text_byte  = '0;
    logic        last_byte  = 1'b0;
    logic        res_valid;
    logic        res_stall  = 1'b0;
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;

    int          mismatch_count;
    int          dates_pending;

    // bytes of the text about to be sent
    logic [7:0]  text_buf[$];
    int          sent_bytes  = 0;
    int          cycle_count = 0;
    // set while inside the stretch with no gaps and no stalls
    bit          steady      = 1'b0;

    always #1 clk = ~clk;

    iso_date_text_validator_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .text_byte  (text_byte),
        .last_byte  (last_byte),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .valid_res  (valid_res),
        .year       (year),
        .month      (month),
        .day        (day)
    );

    iso_date_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .text_byte      (text_byte),
        .last_byte      (last_byte),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .valid_res      (valid_res),
        .year           (year),
        .month          (month),
        .day            (day),
        .mismatch_count (mismatch_count),
        .dates_pending  (dates_pending)
    );

    // result side back-pressure, off during the steady stretch
    always @(posedge clk)
        res_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

    // hang guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // random byte, leaning toward the characters the parser cares about
    function automatic logic [7:0] noise_byte();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return 8'($urandom_range(CH_ZERO, CH_NINE));
        else if (k == 3)
            return CH_MINUS;
        else if (k == 4)
            return (($urandom_range(0, 1) == 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
        else if (k == 5)
            return CH_NUL;
        else if (k == 6)
            return CH_PLUS;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // one number field with optional whitespace, sign, leading zero and nul tail
    function automatic void put_number(input int unsigned v, input bit in_day);
        string digits;
        int    k;
        int    i;
        if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 2))
                text_buf.push_back(($urandom_range(0, 2) == 0) ? CH_SPACE :
                                   8'($urandom_range(CH_TAB, CH_CR)));
        k = $urandom_range(0, 99);
        if (k < 8)
            text_buf.push_back(CH_PLUS);
        else if (in_day && k < 11)
            text_buf.push_back(CH_MINUS);
        if ($urandom_range(0, 9) == 0)
            text_buf.push_back(CH_ZERO);
        digits = $sformatf("%0d", v);
        for (i = 0; i < digits.len(); i++)
            text_buf.push_back(digits[i]);
        // nul ends the number, whatever follows in the field is dropped
        if ($urandom_range(0, 11) == 0) begin
            text_buf.push_back(CH_NUL);
            repeat ($urandom_range(0, 2))
                text_buf.push_back(noise_byte());
        end
    endfunction

    // push the buffered text through the byte channel, last flag on its final byte
    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++) begin
            while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
            byte_valid <= 1'b1;
            text_byte  <= text_buf[i];
            last_byte  <= (i == text_buf.size() - 1);
            @(posedge clk);
            while (byte_stall)
                @(posedge clk);
            sent_bytes++;
            steady <= (sent_bytes >= 400 && sent_bytes < 600);
        end
        text_buf.delete();
    endtask

    // directed text, '#' stands for a nul byte
    task automatic send_literal(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back((s[i] == "#") ? CH_NUL : s[i]);
        send_text();
    endtask

    initial begin
        int          k;
        int          pos;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leap rule: by 4, by 100, by 400
        send_literal("2024-02-29");
        send_literal("1900-2-29");
        send_literal("2000-2-29");
        // field extremes and saturation
        send_literal("9999-12-31");
        send_literal("1-1-1");
        send_literal("10000-1-1");
        send_literal("0-0-0");
        // empty fields, too few separators, minus on the day
        send_literal("--");
        send_literal("7");
        send_literal("1-2--3");
        // whitespace and sign up front, a day past the month's end, space after the digits
        send_literal(" +4-\t04-30");
        send_literal("4-4-31");
        send_literal("5-5-5 ");
        // nul ends a number, later separator in the day field
        send_literal("8#x-9#-3#-z");
        send_literal("6-6-6-1");

        while (sent_bytes < BYTE_GOAL) begin
            k = $urandom_range(0, 99);
            if (k < 15) begin
                // pure noise
                repeat ($urandom_range(1, 10))
                    text_buf.push_back(noise_byte());
            end
            else begin
                // well-formed date, mangled in one place for k below 30
                case ($urandom_range(0, 9))
                    0:       yr = $urandom_range(1, 24) * 400;
                    1:       yr = $urandom_range(1, 99) * 100;
                    2:       yr = $urandom_range(1, 2499) * 4;
                    3:       yr = $urandom_range(10000, 99999);
                    4:       yr = 0;
                    default: yr = $urandom_range(1, 9999);
                endcase
                case ($urandom_range(0, 19))
                    0:             mo = 0;
                    1:             mo = $urandom_range(13, 99);
                    2, 3, 4, 5:    mo = 2;
                    default:       mo = $urandom_range(1, 12);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:    dy = $urandom_range(1, 31);
                    8:             dy = 0;
                    9:             dy = $urandom_range(32, 99);
                    default:       dy = $urandom_range(27, 31);
                endcase
                put_number(yr, 1'b0);
                text_buf.push_back(CH_MINUS);
                put_number(mo, 1'b0);
                text_buf.push_back(CH_MINUS);
                put_number(dy, 1'b1);
                if (k < 30) begin
                    pos = $urandom_range(0, text_buf.size() - 1);
                    if ($urandom_range(0, 1) == 1)
                        text_buf[pos] = noise_byte();
                    else
                        text_buf.insert(pos, noise_byte());
                end
            end
            send_text();
        end
        byte_valid <= 1'b0;

        // drain: wait for every expected word, then for the DRAIN_CYCLES margin
        @(posedge clk);
        while (dates_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
